// ===== src/mik_pkg.sv =====
`default_nettype none

package mik_pkg;

  localparam int Wheels = 4;
  localparam int WheelFl = 0;
  localparam int WheelFr = 1;
  localparam int WheelRr = 2;
  localparam int WheelRl = 3;

  localparam int VelW = 16;
  localparam int GeomW = 16;
  localparam int RadW = 16;
  localparam int MaxW = 15;
  localparam int OutW = 16;

  // x*1024 +/- y*1024 +/- g*w stays inside 33 signed bits, its magnitude in 32
  localparam int MixW = 33;
  localparam int MagW = 32;
  localparam int ProdW = MagW + RadW;
  localparam int NumW = ProdW + MaxW;
  localparam int FracShift = 28;
  localparam int PlainW = ProdW - FracShift;
  localparam int QuotW = MaxW;

  localparam int AddrW = 4;
  localparam int DataW = 32;
  localparam int IdxW = 2;

  localparam logic [IdxW-1:0] RegGeom = 2'd0;
  localparam logic [IdxW-1:0] RegRadius = 2'd1;
  localparam logic [IdxW-1:0] RegMax = 2'd2;

  localparam logic [GeomW-1:0] GeomReset = 16'd835;
  localparam logic [RadW-1:0] RadiusReset = 16'd3325;
  localparam logic [MaxW-1:0] MaxReset = 15'd1000;

  typedef struct packed {
    logic neg;
    logic scaled;
    logic [PlainW-1:0] plain;
  } side_t;

endpackage

`default_nettype wire

// ===== src/mik_front.sv =====
`default_nettype none

module mik_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic signed [mik_pkg::VelW-1:0] vel_x_i,
  input  logic signed [mik_pkg::VelW-1:0] vel_y_i,
  input  logic signed [mik_pkg::VelW-1:0] yaw_rate_i,
  input  logic [mik_pkg::GeomW-1:0] geometry_sum_i,
  input  logic [mik_pkg::RadW-1:0] inverse_radius_i,
  output logic valid_o,
  output logic [mik_pkg::Wheels-1:0][mik_pkg::ProdW-1:0] prod_o,
  output logic [mik_pkg::Wheels-1:0] neg_o
);
  import mik_pkg::*;

  logic signed [MixW-1:0] x_d, y_d, t_d, x_q, y_q, t_q;
  logic signed [MixW-1:0] num [Wheels];
  logic [Wheels-1:0][MagW-1:0] mag_d, mag_q;
  logic [Wheels-1:0] neg_d, neg_q;
  logic [Wheels-1:0][ProdW-1:0] prod_d, prod_q;
  logic [Wheels-1:0] negc_q;
  logic va_q, vb_q, vc_q;

  // stage a: scale the linear terms, one multiply for the yaw term
  assign x_d = MixW'($signed({vel_x_i, 10'b0}));
  assign y_d = MixW'($signed({vel_y_i, 10'b0}));
  assign t_d = MixW'($signed({1'b0, geometry_sum_i})) * MixW'(yaw_rate_i);

  // stage b: wheel mixing and magnitude
  assign num[WheelFl] = x_q - y_q - t_q;
  assign num[WheelFr] = x_q + y_q + t_q;
  assign num[WheelRr] = x_q - y_q + t_q;
  assign num[WheelRl] = x_q + y_q - t_q;

  always_comb begin
    for (int i = 0; i < Wheels; i++) begin
      neg_d[i] = num[i][MixW-1];
      mag_d[i] = MagW'(num[i][MixW-1] ? -num[i] : num[i]);
    end
  end

  // stage c: times inverse radius
  always_comb begin
    for (int i = 0; i < Wheels; i++) begin
      prod_d[i] = ProdW'(mag_q[i]) * ProdW'(inverse_radius_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      t_q <= t_d;
      mag_q <= mag_d;
      neg_q <= neg_d;
      prod_q <= prod_d;
      negc_q <= neg_q;
    end
  end

  assign valid_o = vc_q;
  assign prod_o = prod_q;
  assign neg_o = negc_q;

endmodule

`default_nettype wire

// ===== src/mik_peak.sv =====
`default_nettype none

module mik_peak (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic [mik_pkg::Wheels-1:0][mik_pkg::ProdW-1:0] prod_i,
  input  logic [mik_pkg::Wheels-1:0] neg_i,
  input  logic [mik_pkg::MaxW-1:0] speed_limit_i,
  output logic valid_o,
  output logic [mik_pkg::Wheels-1:0][mik_pkg::NumW-1:0] num_o,
  output logic [mik_pkg::ProdW-1:0] den_o,
  output mik_pkg::side_t [mik_pkg::Wheels-1:0] side_o
);
  import mik_pkg::*;

  logic [ProdW-1:0] m01_d, m23_d, m01_q, m23_q, big_d, big_q;
  logic [Wheels-1:0][ProdW-1:0] pd_q, pe_q;
  logic [Wheels-1:0] nd_q, ne_q;
  logic [ProdW-1:0] lim_fix;
  logic scaled;
  logic [Wheels-1:0][NumW-1:0] num_d, num_q;
  side_t [Wheels-1:0] side_d, side_q;
  logic [ProdW-1:0] den_q;
  logic vd_q, ve_q, vf_q;

  // stage d: pairwise max
  assign m01_d = (prod_i[1] > prod_i[0]) ? prod_i[1] : prod_i[0];
  assign m23_d = (prod_i[3] > prod_i[2]) ? prod_i[3] : prod_i[2];

  // stage e: largest magnitude
  assign big_d = (m23_q > m01_q) ? m23_q : m01_q;

  // stage f: limit test and the dividend for the ratio
  assign lim_fix = ProdW'({speed_limit_i, {FracShift{1'b0}}});
  assign scaled = big_q > lim_fix;

  always_comb begin
    for (int i = 0; i < Wheels; i++) begin
      num_d[i] = NumW'(pe_q[i]) * NumW'(speed_limit_i);
      side_d[i].neg = ne_q[i];
      side_d[i].scaled = scaled;
      side_d[i].plain = pe_q[i][ProdW-1:FracShift];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= valid_i;
      ve_q <= vd_q;
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m01_q <= m01_d;
      m23_q <= m23_d;
      pd_q <= prod_i;
      nd_q <= neg_i;
      big_q <= big_d;
      pe_q <= pd_q;
      ne_q <= nd_q;
      num_q <= num_d;
      den_q <= big_q;
      side_q <= side_d;
    end
  end

  assign valid_o = vf_q;
  assign num_o = num_q;
  assign den_o = den_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

// ===== src/mik_div_lane.sv =====
`default_nettype none

// restoring divider, one quotient bit per stage, msb first
module mik_div_lane (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic [mik_pkg::NumW-1:0] num_i,
  input  logic [mik_pkg::ProdW-1:0] den_i,
  input  mik_pkg::side_t side_i,
  output logic valid_o,
  output logic [mik_pkg::QuotW-1:0] quot_o,
  output mik_pkg::side_t side_o
);
  import mik_pkg::*;

  logic [NumW-1:0] rem [QuotW+1];
  logic [ProdW-1:0] den [QuotW+1];
  logic [QuotW-1:0] quot [QuotW+1];
  side_t side [QuotW+1];
  logic [QuotW:0] valid;

  assign rem[0] = num_i;
  assign den[0] = den_i;
  assign quot[0] = '0;
  assign side[0] = side_i;
  assign valid[0] = valid_i;

  for (genvar s = 0; s < QuotW; s++) begin : g_stage
    localparam int Sh = QuotW - 1 - s;
    logic [NumW-1:0] shifted;
    logic ge;

    // quotient fits QuotW bits, so remainder stays below den << (Sh+1)
    assign shifted = NumW'(den[s]) << Sh;
    assign ge = rem[s] >= shifted;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid[s+1] <= 1'b0;
      end else if (en_i) begin
        valid[s+1] <= valid[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[s+1] <= ge ? (rem[s] - shifted) : rem[s];
        den[s+1] <= den[s];
        quot[s+1] <= {quot[s][QuotW-2:0], ge};
        side[s+1] <= side[s];
      end
    end
  end

  assign valid_o = valid[QuotW];
  assign quot_o = quot[QuotW];
  assign side_o = side[QuotW];

endmodule

`default_nettype wire

// ===== src/mecanum_inverse_kinematics_unit.sv =====
`default_nettype none

// channel   direction  handshake               payload
// command   in         in_valid_i / in_stall_o  vel_x_i, vel_y_i, yaw_rate_i
// wheels    out        out_valid_o / out_stall_i
//                        front_left_o, front_right_o, rear_right_o, rear_left_o,
//                        was_scaled_o
// config    apb        psel/penable/pwrite      geometry_sum, inverse_radius, speed_limit
//
// one transaction per cycle unless the output stalls. a command passes the mixing and
// radius multiply stages, the peak search stages, the 15-stage per-wheel ratio divider
// and an output register; throughput is one command every cycle while not stalled.
// when a result waits at the output, the whole pipeline holds and in_stall_o rises.
// reset empties the pipeline and loads the register defaults; there is no clearing pass.
module mecanum_inverse_kinematics_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic signed [mik_pkg::VelW-1:0] vel_x_i,
  input  logic signed [mik_pkg::VelW-1:0] vel_y_i,
  input  logic signed [mik_pkg::VelW-1:0] yaw_rate_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic signed [mik_pkg::OutW-1:0] front_left_o,
  output logic signed [mik_pkg::OutW-1:0] front_right_o,
  output logic signed [mik_pkg::OutW-1:0] rear_right_o,
  output logic signed [mik_pkg::OutW-1:0] rear_left_o,
  output logic was_scaled_o,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [mik_pkg::AddrW-1:0] paddr,
  input  logic [mik_pkg::DataW-1:0] pwdata,
  output logic [mik_pkg::DataW-1:0] prdata,
  output logic pready
);
  import mik_pkg::*;

  logic [GeomW-1:0] geom_q;
  logic [RadW-1:0] radius_q;
  logic [MaxW-1:0] max_q;
  logic advance;

  logic front_valid;
  logic [Wheels-1:0][ProdW-1:0] prod;
  logic [Wheels-1:0] neg;
  logic peak_valid;
  logic [Wheels-1:0][NumW-1:0] num;
  logic [ProdW-1:0] den;
  side_t [Wheels-1:0] side;
  logic [Wheels-1:0] lane_valid;
  logic [Wheels-1:0][QuotW-1:0] quot;
  side_t [Wheels-1:0] lane_side;

  logic [Wheels-1:0][OutW-1:0] wheel_d, wheel_q;
  logic scaled_q;
  logic out_valid_q;

  // apb registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q <= GeomReset;
      radius_q <= RadiusReset;
      max_q <= MaxReset;
    end else if (psel && penable && pwrite) begin
      case (paddr[AddrW-1:2])
        RegGeom: geom_q <= pwdata[GeomW-1:0];
        RegRadius: radius_q <= pwdata[RadW-1:0];
        RegMax: max_q <= pwdata[MaxW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[AddrW-1:2])
      RegGeom: prdata = DataW'(geom_q);
      RegRadius: prdata = DataW'(radius_q);
      RegMax: prdata = DataW'(max_q);
      default: prdata = '0;
    endcase
  end

  // whole pipeline moves unless a result sits unaccepted at the output
  assign advance = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  mik_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .valid_i         (in_valid_i),
    .vel_x_i         (vel_x_i),
    .vel_y_i         (vel_y_i),
    .yaw_rate_i      (yaw_rate_i),
    .geometry_sum_i  (geom_q),
    .inverse_radius_i(radius_q),
    .valid_o         (front_valid),
    .prod_o          (prod),
    .neg_o           (neg)
  );

  mik_peak u_peak (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .valid_i      (front_valid),
    .prod_i       (prod),
    .neg_i        (neg),
    .speed_limit_i(max_q),
    .valid_o      (peak_valid),
    .num_o        (num),
    .den_o        (den),
    .side_o       (side)
  );

  for (genvar w = 0; w < Wheels; w++) begin : g_lane
    logic [QuotW-1:0] mag;

    mik_div_lane u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .valid_i(peak_valid),
      .num_i  (num[w]),
      .den_i  (den),
      .side_i (side[w]),
      .valid_o(lane_valid[w]),
      .quot_o (quot[w]),
      .side_o (lane_side[w])
    );

    // unscaled speed is the product's integer part, held to the limit
    always_comb begin
      if (lane_side[w].scaled) begin
        mag = quot[w];
      end else if (lane_side[w].plain > PlainW'(max_q)) begin
        mag = max_q;
      end else begin
        mag = lane_side[w].plain[QuotW-1:0];
      end
      wheel_d[w] = lane_side[w].neg ? -OutW'(mag) : OutW'(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= &lane_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      wheel_q <= wheel_d;
      scaled_q <= lane_side[0].scaled;
    end
  end

  assign out_valid_o = out_valid_q;
  assign front_left_o = wheel_q[WheelFl];
  assign front_right_o = wheel_q[WheelFr];
  assign rear_right_o = wheel_q[WheelRr];
  assign rear_left_o = wheel_q[WheelRl];
  assign was_scaled_o = scaled_q;

  function automatic logic [OutW-1:0] mag16(input logic [OutW-1:0] v);
    return v[OutW-1] ? OutW'(-v) : v;
  endfunction

`ifndef SYNTHESIS
  a_within_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mag16(front_left_o) <= {1'b0, max_q}) &&
                    (mag16(front_right_o) <= {1'b0, max_q}) &&
                    (mag16(rear_right_o) <= {1'b0, max_q}) &&
                    (mag16(rear_left_o) <= {1'b0, max_q}))
    else $error("wheel speed beyond configured maximum");

  a_scaled_hits_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_scaled_o |-> (mag16(front_left_o) == {1'b0, max_q}) ||
                                    (mag16(front_right_o) == {1'b0, max_q}) ||
                                    (mag16(rear_right_o) == {1'b0, max_q}) ||
                                    (mag16(rear_left_o) == {1'b0, max_q}))
    else $error("scaled transaction with no wheel at the maximum");

  a_zero_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (max_q == '0) |-> (front_left_o == '0) && (front_right_o == '0) &&
                                      (rear_right_o == '0) && (rear_left_o == '0))
    else $error("nonzero wheel with zero maximum");
`endif

endmodule

`default_nettype wire

// ===== sim/mecanum_inverse_kinematics_unit_test.sv =====
`default_nettype none

module mecanum_inverse_kinematics_unit_test;
  import mik_pkg::*;

  localparam logic [IdxW-1:0] RegUnused = 2'd3;
  localparam int PhaseItems = 66;
  localparam int RandomPhases = 8;

  typedef struct packed {
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic signed [VelW-1:0] yaw_rate;
    logic signed [OutW-1:0] fl;
    logic signed [OutW-1:0] fr;
    logic signed [OutW-1:0] rr;
    logic signed [OutW-1:0] rl;
    logic scaled;
  } wheel_set_t;

  class wheel_scoreboard;
    logic [GeomW-1:0] geometry_sum;
    logic [RadW-1:0] inverse_radius;
    logic [MaxW-1:0] speed_limit;
    wheel_set_t wheels_q[$];
    int errors;

    function new();
      geometry_sum = GeomReset;
      inverse_radius = RadiusReset;
      speed_limit = MaxReset;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR at %0t: %s", $time, msg);
    endtask

    function void set_register(logic [IdxW-1:0] idx, logic [DataW-1:0] value);
      case (idx)
        RegGeom: begin
          geometry_sum = value[GeomW-1:0];
        end
        RegRadius: begin
          inverse_radius = value[RadW-1:0];
        end
        RegMax: begin
          speed_limit = value[MaxW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int pending();
      return wheels_q.size();
    endfunction

    // exact integer mixing, then common ratio scaling against the largest wheel
    function void note_command(logic signed [VelW-1:0] x, logic signed [VelW-1:0] y,
                               logic signed [VelW-1:0] w);
      longint mix [Wheels];
      longint unsigned mag [Wheels];
      logic signed [OutW-1:0] speed [Wheels];
      longint px, py, pt, abs_v;
      longint unsigned largest, q, limit;
      logic signed [OutW-1:0] q16;
      logic scaled;
      wheel_set_t want;
      px = longint'(x) * 1024;
      py = longint'(y) * 1024;
      pt = longint'(geometry_sum) * longint'(w);
      mix[WheelFl] = px - py - pt;
      mix[WheelFr] = px + py + pt;
      mix[WheelRr] = px - py + pt;
      mix[WheelRl] = px + py - pt;
      largest = 0;
      limit = longint'(speed_limit);
      for (int i = 0; i < Wheels; i++) begin
        abs_v = (mix[i] < 0) ? -mix[i] : mix[i];
        mag[i] = longint'(abs_v) * longint'(inverse_radius);
        if (mag[i] > largest) largest = mag[i];
      end
      scaled = largest > (limit << FracShift);
      for (int i = 0; i < Wheels; i++) begin
        if (scaled) q = (mag[i] * limit) / largest;
        else q = mag[i] >> FracShift;
        if (q > limit) q = limit;
        q16 = q[OutW-1:0];
        speed[i] = (mix[i] < 0) ? -q16 : q16;
      end
      want.vel_x = x;
      want.vel_y = y;
      want.yaw_rate = w;
      want.fl = speed[WheelFl];
      want.fr = speed[WheelFr];
      want.rr = speed[WheelRr];
      want.rl = speed[WheelRl];
      want.scaled = scaled;
      wheels_q.push_back(want);
    endfunction

    task compare_field(string name, int got, int want, wheel_set_t cmd);
      if (got != want)
        report($sformatf("%s got %0d want %0d (vx %0d vy %0d wz %0d)", name, got, want,
                         cmd.vel_x, cmd.vel_y, cmd.yaw_rate));
    endtask

    task check_wheels(logic signed [OutW-1:0] fl, logic signed [OutW-1:0] fr,
                      logic signed [OutW-1:0] rr, logic signed [OutW-1:0] rl,
                      logic scaled);
      wheel_set_t want;
      if (wheels_q.size() == 0) begin
        report("wheel transaction with no command outstanding");
        return;
      end
      want = wheels_q.pop_front();
      compare_field("front_left", fl, want.fl, want);
      compare_field("front_right", fr, want.fr, want);
      compare_field("rear_right", rr, want.rr, want);
      compare_field("rear_left", rl, want.rl, want);
      compare_field("was_scaled", scaled, want.scaled, want);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [VelW-1:0] vel_x_i = '0;
  logic signed [VelW-1:0] vel_y_i = '0;
  logic signed [VelW-1:0] yaw_rate_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [OutW-1:0] front_left_o;
  logic signed [OutW-1:0] front_right_o;
  logic signed [OutW-1:0] rear_right_o;
  logic signed [OutW-1:0] rear_left_o;
  logic was_scaled_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  wheel_scoreboard sb;
  logic steady_in = 1'b0;
  logic steady_out = 1'b0;

  mecanum_inverse_kinematics_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // all tasks start and end on a rising edge
  task automatic write_register(input logic [IdxW-1:0] idx, input logic [DataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic load_config(input logic [GeomW-1:0] g, input logic [RadW-1:0] r,
                             input logic [MaxW-1:0] m);
    write_register(RegGeom, DataW'(g));
    write_register(RegRadius, DataW'(r));
    write_register(RegMax, DataW'(m));
  endtask

  task automatic send_command(input logic signed [VelW-1:0] x,
                              input logic signed [VelW-1:0] y,
                              input logic signed [VelW-1:0] w);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vel_x_i <= x;
    vel_y_i <= y;
    yaw_rate_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command(x, y, w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [VelW-1:0] pick_velocity();
    logic signed [VelW-1:0] v;
    case ($urandom_range(0, 5))
      0, 1, 2: v = VelW'($urandom);
      3: v = VelW'($urandom_range(0, 800)) - 16'sd400;
      4: v = VelW'($urandom_range(0, 8000)) - 16'sd4000;
      default: begin
        case ($urandom_range(0, 4))
          0: v = 16'sh7fff;
          1: v = 16'sh8000;
          2: v = 16'sd0;
          3: v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic random_config();
    logic [GeomW-1:0] g;
    logic [RadW-1:0] r;
    logic [MaxW-1:0] m;
    case ($urandom_range(0, 5))
      0: g = '0;
      1: g = '1;
      2, 3: g = GeomW'($urandom_range(0, 2000));
      default: g = GeomW'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: r = RadW'(1);
      1: r = '1;
      2, 3: r = RadW'($urandom_range(1, 4000));
      default: r = RadW'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 5))
      0: m = MaxW'(1);
      1: m = '1;
      2, 3: m = MaxW'($urandom_range(1, 2000));
      default: m = MaxW'($urandom_range(1, 32767));
    endcase
    load_config(g, r, m);
  endtask

  // result side: random stall after each transaction, quiet stretches now and then
  initial begin
    int taken;
    int hold;
    taken = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_wheels(front_left_o, front_right_o, rear_right_o, rear_left_o,
                        was_scaled_o);
        taken++;
        if (taken % 25 == 0) steady_out = ($urandom_range(0, 3) == 0);
        hold = steady_out ? 0 : $urandom_range(0, 12);
        if (hold > 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: extremes of every field
    send_command(16'sd0, 16'sd0, 16'sd0);
    send_command(16'sh7fff, 16'sd0, 16'sd0);
    send_command(16'sh8000, 16'sd0, 16'sd0);
    send_command(16'sd0, 16'sh7fff, 16'sd0);
    send_command(16'sd0, 16'sh8000, 16'sd0);
    send_command(16'sd0, 16'sd0, 16'sh7fff);
    send_command(16'sd0, 16'sd0, 16'sh8000);
    send_command(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_command(16'sh8000, 16'sh8000, 16'sh8000);
    send_command(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_command(16'sd100, 16'sd50, -16'sd20);
    send_command(16'sd1, 16'sd1, 16'sd1);
    drain();

    // speed landing exactly on the maximum, plus masked register writes
    write_register(RegGeom, 32'habcd_0000);
    write_register(RegRadius, 32'd16384);
    write_register(RegMax, 32'h0000_83e8);
    send_command(16'sd16000, 16'sd0, 16'sd0);
    send_command(-16'sd16000, 16'sd0, 16'sd0);
    send_command(16'sd16001, 16'sd0, 16'sd0);
    send_command(16'sd0, 16'sd16000, 16'sd0);
    send_command(16'sd8000, 16'sd8000, 16'sd0);
    drain();

    // zero maximum
    load_config(GeomReset, RadiusReset, '0);
    send_command(16'sd0, 16'sd0, 16'sd0);
    send_command(16'sd1, 16'sd0, 16'sd0);
    send_command(16'sd0, 16'sd0, 16'sd1);
    drain();

    // zero inverse radius
    load_config(GeomReset, '0, '1);
    send_command(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_command(16'sh8000, 16'sh7fff, 16'sh8000);
    drain();

    // largest geometry and radius, write to an unused index must be ignored
    load_config('1, '1, '1);
    write_register(RegUnused, $urandom);
    send_command(16'sh8000, 16'sh8000, 16'sh8000);
    send_command(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_command(16'sd1, -16'sd1, 16'sd1);
    drain();

    for (int p = 0; p < RandomPhases; p++) begin
      if (p > 0) random_config();
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 16 == 0) steady_in = ($urandom_range(0, 3) == 0);
        send_command(pick_velocity(), pick_velocity(), pick_velocity());
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
